// ----- rtl/core/bpfc_pkg.sv -----
package bpfc_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int TOP_ORDER = 10;
    localparam int ORDER_W   = 4;
    localparam int CLIMB_TOP = (TOP_ORDER < PAGE_W) ? TOP_ORDER : PAGE_W;
    localparam int RC_W      = 8;
    localparam int TOTAL_W   = 13;
    localparam int SUM_W     = TOTAL_W + 4;

    localparam logic [RC_W-1:0]    RC_RESET  = RC_W'(1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        ST_FREED = 2'd0,
        ST_REFD  = 2'd1,
        ST_ZERO  = 2'd2
    } t_status;

    typedef struct packed {
        logic              active;
        logic [PAGE_W-1:0] addr;
    } t_sweep;

    function automatic logic [PAGE_W-1:0] align_mask(input logic [ORDER_W-1:0] order);
        return {PAGE_W{1'b1}} << order;
    endfunction

    function automatic logic [PAGE_W-1:0] bm_offset(input logic [ORDER_W-1:0] order,
                                                    input logic [PAGE_W-1:0]  rel);
        logic [PAGE_W:0]    region;
        logic [ORDER_W:0]   shamt;
        region = (PAGE_W+1)'(NUM_PAGES) - ((PAGE_W+1)'(NUM_PAGES) >> order);
        shamt  = {1'b0, order} + (ORDER_W+1)'(1);
        return region[PAGE_W-1:0] + (rel >> shamt);
    endfunction

endpackage

// ----- rtl/core/bpfc_refcnt.sv -----
module bpfc_refcnt import bpfc_pkg::*; (
    input  logic              i_clk,
    input  t_sweep            i_sweep,
    input  logic [PAGE_W-1:0] i_rd_addr,
    input  logic              i_dec_en,
    input  logic [PAGE_W-1:0] i_dec_addr,
    output logic [RC_W-1:0]   o_rd_data
);

    logic [RC_W-1:0]   mem [NUM_PAGES];
    logic [RC_W-1:0]   r_rd_data;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
    logic [RC_W-1:0]   wr_data;

    // decrement writes back the value read in the previous cycle
    always_comb begin
        wr_en   = i_sweep.active | i_dec_en;
        wr_addr = i_sweep.active ? i_sweep.addr : i_dec_addr;
        wr_data = i_sweep.active ? RC_RESET : (r_rd_data - RC_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/bpfc_pairmap.sv -----
module bpfc_pairmap import bpfc_pkg::*; (
    input  logic              i_clk,
    input  t_sweep            i_sweep,
    input  logic [PAGE_W-1:0] i_rd_addr,
    input  logic              i_tgl_en,
    input  logic [PAGE_W-1:0] i_tgl_addr,
    output logic              o_rd_bit
);

    logic              mem [NUM_PAGES];
    logic              r_rd_bit;
    logic              wr_en;
    logic [PAGE_W-1:0] wr_addr;
    logic              wr_bit;

    // toggle writes back the inverse of the bit read in the previous cycle
    always_comb begin
        wr_en   = i_sweep.active | i_tgl_en;
        wr_addr = i_sweep.active ? i_sweep.addr : i_tgl_addr;
        wr_bit  = i_sweep.active ? 1'b0 : ~r_rd_bit;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_bit;
        end
        r_rd_bit <= mem[i_rd_addr];
    end

    assign o_rd_bit = r_rd_bit;

endmodule

// ----- rtl/core/buddy_page_free_coalescer.sv -----
// Buddy page free coalescer.
// Input channel (i_in_valid / o_in_stall) carries a free request: page number
// and block order. Output channel (o_out_valid / i_out_stall) carries one
// result per request: status, coalesced block page, final order, merge count
// and the running free-page total. The configuration channel (i_cfg_valid /
// o_cfg_ready) writes the area base page; it is always ready.
// Sequence: the request is accepted, the reference count is read-modify-written,
// then, for a freed block below the top order, the pair bitmap is visited once
// per merge plus once more when the climb ends on a clear pair bit, and last
// the output register is loaded. The single-port read/write sequencing over
// the two state memories sets this order.
// The next request is accepted while the previous result waits in the output
// register; a stalled receiver holds the result and, once a new request is
// done, holds the block until the register frees up.
// After reset the block sweeps all 4096 addresses of both memories (counts to one,
// pair bits to zero) and holds o_in_stall high; configuration writes are
// taken during the sweep.
module buddy_page_free_coalescer import bpfc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [PAGE_W-1:0]  i_page_number,
    input  logic [ORDER_W-1:0] i_block_order,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [PAGE_W-1:0]  o_block_page,
    output logic [ORDER_W-1:0] o_final_order,
    output logic [ORDER_W-1:0] o_merge_count,
    output logic [TOTAL_W-1:0] o_free_page_total,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [PAGE_W-1:0]  i_cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RC    = 5'b00100,
        S_BM    = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [PAGE_W-1:0]  r_clr_addr, n_clr_addr;
    logic [PAGE_W-1:0]  r_base;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic [ORDER_W-1:0] r_order_in, n_order_in;
    logic [ORDER_W-1:0] r_order, n_order;
    logic [PAGE_W-1:0]  r_rel, n_rel;
    logic [ORDER_W-1:0] r_merges, n_merges;
    t_status            r_status, n_status;
    logic [TOTAL_W-1:0] r_total, n_total;

    logic               r_o_valid;
    t_status            r_o_status;
    logic [PAGE_W-1:0]  r_o_page;
    logic [ORDER_W-1:0] r_o_order;
    logic [ORDER_W-1:0] r_o_merges;
    logic [TOTAL_W-1:0] r_o_total;

    t_sweep             sweep;
    logic [RC_W-1:0]    rc_rd_data;
    logic               rc_dec_en;
    logic               bm_rd_bit;
    logic               bm_tgl_en;
    logic [PAGE_W-1:0]  bm_rd_addr;
    logic [PAGE_W-1:0]  bm_tgl_addr;
    logic               in_accept;
    logic               out_load;
    logic [SUM_W-1:0]   total_sum;
    logic [ORDER_W-1:0] order_up;

    assign in_accept   = i_in_valid & (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_load    = (r_state == S_OUT) & (~r_o_valid | ~i_out_stall);

    assign sweep.active = (r_state == S_CLEAR);
    assign sweep.addr   = r_clr_addr;

    assign total_sum = SUM_W'(r_total) + (SUM_W'(1) << r_order);
    assign order_up  = r_order + ORDER_W'(1);

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_page     = r_page;
        n_order_in = r_order_in;
        n_order    = r_order;
        n_rel      = r_rel;
        n_merges   = r_merges;
        n_status   = r_status;
        n_total    = r_total;
        rc_dec_en  = 1'b0;
        bm_tgl_en  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + PAGE_W'(1);
                if (r_clr_addr == {PAGE_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_page     = i_page_number;
                    n_order_in = i_block_order;
                    n_order    = i_block_order;
                    n_rel      = (i_page_number - r_base) & align_mask(i_block_order);
                    n_merges   = '0;
                    n_state    = S_RC;
                end
            end
            S_RC: begin
                n_state = S_OUT;
                if (rc_rd_data == '0) begin
                    n_status = ST_ZERO;
                end else begin
                    rc_dec_en = 1'b1;
                    if (rc_rd_data == RC_W'(1)) begin
                        n_status = ST_FREED;
                        n_total  = (total_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                   : total_sum[TOTAL_W-1:0];
                        if (r_order < ORDER_W'(CLIMB_TOP)) begin
                            n_state = S_BM;
                        end
                    end else begin
                        n_status = ST_REFD;
                    end
                end
            end
            S_BM: begin
                bm_tgl_en = 1'b1;
                if (!bm_rd_bit) begin
                    n_state = S_OUT;
                end else begin
                    n_merges = r_merges + ORDER_W'(1);
                    n_order  = order_up;
                    n_rel    = r_rel & align_mask(order_up);
                    if (order_up >= ORDER_W'(CLIMB_TOP)) begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign bm_rd_addr  = bm_offset(n_order, n_rel);
    assign bm_tgl_addr = bm_offset(r_order, r_rel);

    bpfc_refcnt u_refcnt (
        .i_clk      (i_clk),
        .i_sweep    (sweep),
        .i_rd_addr  (i_page_number),
        .i_dec_en   (rc_dec_en),
        .i_dec_addr (r_page),
        .o_rd_data  (rc_rd_data)
    );

    bpfc_pairmap u_pairmap (
        .i_clk      (i_clk),
        .i_sweep    (sweep),
        .i_rd_addr  (bm_rd_addr),
        .i_tgl_en   (bm_tgl_en),
        .i_tgl_addr (bm_tgl_addr),
        .o_rd_bit   (bm_rd_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_base     <= '0;
            r_total    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_total    <= n_total;
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page     <= n_page;
        r_order_in <= n_order_in;
        r_order    <= n_order;
        r_rel      <= n_rel;
        r_merges   <= n_merges;
        r_status   <= n_status;
        if (out_load) begin
            r_o_status <= r_status;
            r_o_total  <= r_total;
            if (r_status == ST_FREED) begin
                r_o_page   <= r_base + r_rel;
                r_o_order  <= r_order;
                r_o_merges <= r_merges;
            end else begin
                r_o_page   <= r_page;
                r_o_order  <= r_order_in;
                r_o_merges <= '0;
            end
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_status          = r_o_status;
    assign o_block_page      = r_o_page;
    assign o_final_order     = r_o_order;
    assign o_merge_count     = r_o_merges;
    assign o_free_page_total = r_o_total;

endmodule
